[rtl/assert_macros.svh]
// assertion helpers for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define BDUT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define BDUT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bdut_pkg.sv]
package bdut_pkg;

   // calendar constants
   localparam logic [31:0] EPOCH_DAYS     = 32'd719561;
   localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
   localparam logic [6:0]  HOUR_MASK      = 7'h7F;
   localparam logic [6:0]  CENTURY_YEARS  = 7'd100;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [4:0]  DAYS_PER_MONTH = 5'd30;
   localparam logic [7:0]  MONTH_SHIFT    = 8'd12;
   localparam logic [7:0]  LAST_EARLY_MON = 8'd2;

   // reciprocals for division by constants
   // x / 25 for x < 2^14: (x * 20972) >> 19
   localparam logic [14:0] RECIP_25       = 15'd20972;
   localparam int          RECIP_25_SHIFT = 19;
   // n / 5 for n < 512: (n * 410) >> 11
   localparam logic [8:0]  RECIP_5        = 9'd410;
   localparam int          RECIP_5_SHIFT  = 11;

   // width of the time of day in seconds (max 316065)
   localparam int TOD_W = 19;

   // shifted calendar date and time of day
   typedef struct packed {
      logic [15:0]      year;
      logic [7:0]       mon;
      logic [7:0]       day;
      logic [TOD_W-1:0] tod;
   } cal_type;

   // day number relative to the epoch and time of day
   typedef struct packed {
      logic [31:0]      days;
      logic [TOD_W-1:0] tod;
   } day_type;

   // high nibble times ten plus low nibble, no digit check
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'b0000, b[7:4]};
      lo = {4'b0000, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

endpackage

[rtl/bdut_decode.sv]
module bdut_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  logic [7:0]        seconds_bcd,
   input  logic [7:0]        minutes_bcd,
   input  logic [7:0]        hours_bcd,
   input  logic [7:0]        day_bcd,
   input  logic [7:0]        month_bcd,
   input  logic [7:0]        year_bcd,
   input  logic [7:0]        century_bcd,
   output logic              out_valid,
   input  logic              out_stall,
   output bdut_pkg::cal_type out_data
);

   typedef struct packed {
      logic [7:0] sec;
      logic [7:0] min;
      logic [6:0] hr;
      logic [7:0] day;
      logic [7:0] mon;
      logic [7:0] yr2;
      logic [7:0] cen;
   } bin_type;

   logic              s1_valid_ff;
   logic              s2_valid_ff;
   bin_type           s1_data_ff;
   bin_type           s1_data_in;
   bdut_pkg::cal_type s2_data_ff;
   bdut_pkg::cal_type s2_data_in;
   logic              s1_en;
   logic              s2_en;
   logic [7:0]        hr_bin;
   logic [15:0]       year_full;
   logic [14:0]       cen_years;
   logic              early_month;

   // a stage loads when it is empty or its content moves on
   assign s2_en    = !s2_valid_ff || !out_stall;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_stall = !s1_en;

   // stage 1: bcd bytes to binary
   always_comb begin
      hr_bin         = bdut_pkg::bcd_to_bin({1'b0, hours_bcd[6:0] & bdut_pkg::HOUR_MASK});
      s1_data_in.sec = bdut_pkg::bcd_to_bin(seconds_bcd);
      s1_data_in.min = bdut_pkg::bcd_to_bin(minutes_bcd);
      s1_data_in.hr  = hr_bin[6:0];
      s1_data_in.day = bdut_pkg::bcd_to_bin(day_bcd);
      s1_data_in.mon = bdut_pkg::bcd_to_bin(month_bcd);
      s1_data_in.yr2 = bdut_pkg::bcd_to_bin(year_bcd);
      s1_data_in.cen = bdut_pkg::bcd_to_bin(century_bcd);
   end

   // stage 2: full year, march-based month, time of day
   always_comb begin
      cen_years   = 15'(s1_data_ff.cen) * 15'(bdut_pkg::CENTURY_YEARS);
      year_full   = 16'(s1_data_ff.yr2) + 16'(cen_years);
      early_month = s1_data_ff.mon <= bdut_pkg::LAST_EARLY_MON;
      s2_data_in.day = s1_data_ff.day;
      if (early_month) begin
         s2_data_in.mon  = s1_data_ff.mon + bdut_pkg::MONTH_SHIFT;
         s2_data_in.year = year_full - 16'd1;
      end else begin
         s2_data_in.mon  = s1_data_ff.mon;
         s2_data_in.year = year_full;
      end
      s2_data_in.tod = bdut_pkg::TOD_W'(s1_data_ff.hr) *
                       bdut_pkg::TOD_W'(bdut_pkg::SECS_PER_HOUR) +
                       bdut_pkg::TOD_W'(s1_data_ff.min) *
                       bdut_pkg::TOD_W'(bdut_pkg::SECS_PER_MIN) +
                       bdut_pkg::TOD_W'(s1_data_ff.sec);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_data_ff <= s1_data_in;
      end
      if (s2_en) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

[rtl/bdut_days.sv]
module bdut_days (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  bdut_pkg::cal_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output bdut_pkg::day_type out_data
);

   typedef struct packed {
      logic [24:0]                y365;
      logic [13:0]                q4;
      logic [28:0]                p100;
      logic [26:0]                p400;
      logic [8:0]                 n3;
      logic [12:0]                md;
      logic [bdut_pkg::TOD_W-1:0] tod;
   } part_type;

   logic              s3_valid_ff;
   logic              s4_valid_ff;
   part_type          s3_data_ff;
   part_type          s3_data_in;
   bdut_pkg::day_type s4_data_ff;
   bdut_pkg::day_type s4_data_in;
   logic              s3_en;
   logic              s4_en;
   logic [9:0]        q100;
   logic [7:0]        q400;
   logic [17:0]       p5;
   logic [6:0]        m5;

   // a stage loads when it is empty or its content moves on
   assign s4_en    = !s4_valid_ff || !out_stall;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign in_stall = !s3_en;

   // stage 3: year products and month terms
   always_comb begin
      s3_data_in.y365 = 25'(in_data.year) * 25'(bdut_pkg::DAYS_PER_YEAR);
      s3_data_in.q4   = in_data.year[15:2];
      s3_data_in.p100 = 29'(in_data.year[15:2]) * 29'(bdut_pkg::RECIP_25);
      s3_data_in.p400 = 27'(in_data.year[15:4]) * 27'(bdut_pkg::RECIP_25);
      s3_data_in.n3   = (9'(in_data.mon) + 9'd1) * 9'd3;
      s3_data_in.md   = 13'(in_data.mon) * 13'(bdut_pkg::DAYS_PER_MONTH) +
                        13'(in_data.day);
      s3_data_in.tod  = in_data.tod;
   end

   // stage 4: quotients and day sum relative to the epoch
   always_comb begin
      q100 = s3_data_ff.p100[28:bdut_pkg::RECIP_25_SHIFT];
      q400 = s3_data_ff.p400[26:bdut_pkg::RECIP_25_SHIFT];
      p5   = 18'(s3_data_ff.n3) * 18'(bdut_pkg::RECIP_5);
      m5   = p5[17:bdut_pkg::RECIP_5_SHIFT];
      s4_data_in.days = 32'(s3_data_ff.y365) + 32'(s3_data_ff.q4) - 32'(q100) +
                        32'(q400) + 32'(s3_data_ff.md) + 32'(m5) -
                        bdut_pkg::EPOCH_DAYS;
      s4_data_in.tod  = s3_data_ff.tod;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_en) begin
            s3_valid_ff <= in_valid;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_data_ff <= s3_data_in;
      end
      if (s4_en) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

[rtl/bdut_scale.sv]
module bdut_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  bdut_pkg::day_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [31:0]       out_seconds
);

   logic                       s5_valid_ff;
   logic                       s6_valid_ff;
   logic [31:0]                s5_prod_ff;
   logic [31:0]                s5_prod_in;
   logic [bdut_pkg::TOD_W-1:0] s5_tod_ff;
   logic [31:0]                s6_secs_ff;
   logic [31:0]                s6_secs_in;
   logic                       s5_en;
   logic                       s6_en;

   // a stage loads when it is empty or its content moves on
   assign s6_en    = !s6_valid_ff || !out_stall;
   assign s5_en    = !s5_valid_ff || s6_en;
   assign in_stall = !s5_en;

   // stage 5: days to seconds, low 32 bits kept
   assign s5_prod_in = in_data.days * bdut_pkg::SECS_PER_DAY;

   // stage 6: add the time of day
   assign s6_secs_in = s5_prod_ff + 32'(s5_tod_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s5_en) begin
            s5_valid_ff <= in_valid;
         end
         if (s6_en) begin
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_prod_ff <= s5_prod_in;
         s5_tod_ff  <= in_data.tod;
      end
      if (s6_en) begin
         s6_secs_ff <= s6_secs_in;
      end
   end

   assign out_valid   = s6_valid_ff;
   assign out_seconds = s6_secs_ff;

endmodule

[rtl/bcd_rtc_date_to_unix_time.sv]
// throughput: one snapshot per cycle while rsp_stall is low, six-stage pipeline
// a stage holds while the result register waits; empty stages still fill
// reset clears the stage valid bits only; no clearing pass is needed
`include "assert_macros.svh"

module bcd_rtc_date_to_unix_time (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_seconds_bcd,
   input  logic [7:0]  req_minutes_bcd,
   input  logic [7:0]  req_hours_bcd,
   input  logic [7:0]  req_day_bcd,
   input  logic [7:0]  req_month_bcd,
   input  logic [7:0]  req_year_bcd,
   input  logic [7:0]  req_century_bcd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_unix_seconds
);

   logic              cal_valid;
   logic              cal_stall;
   bdut_pkg::cal_type cal_data;
   logic              day_valid;
   logic              day_stall;
   bdut_pkg::day_type day_data;

   // bcd decode and calendar shift
   bdut_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .seconds_bcd (req_seconds_bcd),
      .minutes_bcd (req_minutes_bcd),
      .hours_bcd   (req_hours_bcd),
      .day_bcd     (req_day_bcd),
      .month_bcd   (req_month_bcd),
      .year_bcd    (req_year_bcd),
      .century_bcd (req_century_bcd),
      .out_valid   (cal_valid),
      .out_stall   (cal_stall),
      .out_data    (cal_data)
   );

   // day count relative to the epoch
   bdut_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cal_valid),
      .in_stall  (cal_stall),
      .in_data   (cal_data),
      .out_valid (day_valid),
      .out_stall (day_stall),
      .out_data  (day_data)
   );

   // scale to seconds and add time of day
   bdut_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (day_valid),
      .in_stall    (day_stall),
      .in_data     (day_data),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_seconds (rsp_unix_seconds)
   );

   // input holds back only when the result register is full and stalled
   `BDUT_ASSERT(a_stall_source, clock, reset, req_stall |-> (rsp_valid && rsp_stall),
      "input stall without output backpressure")

   // no result comes out right after reset
   `BDUT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid,
      "result valid right after reset")

   // a new day count comes from a calendar item held first in stage 3, then in stage 4
   `BDUT_ASSERT(a_days_origin, clock, reset, $rose(day_valid) |-> $past(cal_valid, 2),
      "day count without a calendar item")

endmodule
